// ----- src/kea_pkg.sv -----
// shared constants and the cordic arctangent table for the kepler solver
package kea_pkg;

	localparam int E_W = 31;
	localparam int DATA_W = 32;
	localparam int ZW = 34;
	localparam int CORDIC_STEPS = 30;
	localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
	localparam logic signed [ZW-1:0] CORDIC_GAIN_Q30 = 34'sh026DD3B6A;

	function automatic logic signed [ZW-1:0] atan_q30(input int unsigned idx);
		logic signed [ZW-1:0] a;
		case (idx)
			0: a = 34'sh03243F6A8;
			1: a = 34'sh01DAC6705;
			2: a = 34'sh00FADBAFC;
			3: a = 34'sh007F56EA6;
			4: a = 34'sh003FEAB76;
			5: a = 34'sh001FFD55B;
			6: a = 34'sh000FFFAAA;
			7: a = 34'sh0007FFF55;
			8: a = 34'sh0003FFFEA;
			9: a = 34'sh0001FFFFD;
			10: a = 34'sh0000FFFFF;
			11: a = 34'sh00007FFFF;
			12: a = 34'sh00003FFFF;
			13: a = 34'sh00001FFFF;
			14: a = 34'sh00000FFFF;
			15: a = 34'sh000007FFF;
			16: a = 34'sh000003FFF;
			17: a = 34'sh000001FFF;
			18: a = 34'sh000000FFF;
			19: a = 34'sh0000007FF;
			20: a = 34'sh0000003FF;
			21: a = 34'sh0000001FF;
			22: a = 34'sh0000000FF;
			23: a = 34'sh00000007F;
			24: a = 34'sh00000003F;
			25: a = 34'sh00000001F;
			26: a = 34'sh00000000F;
			27: a = 34'sh000000008;
			28: a = 34'sh000000004;
			29: a = 34'sh000000002;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ----- src/kea_in_if.sv -----
// input channel: eccentricity and mean anomaly
interface kea_in_if;
	logic valid;
	logic ready;
	logic [kea_pkg::E_W-1:0] eccentricity;
	logic signed [kea_pkg::DATA_W-1:0] mean_anomaly;

	modport source(output valid, eccentricity, mean_anomaly, input ready);
	modport sink(input valid, eccentricity, mean_anomaly, output ready);
endinterface

// ----- src/kea_out_if.sv -----
// output channel: eccentric anomaly
interface kea_out_if;
	logic valid;
	logic ready;
	logic signed [kea_pkg::DATA_W-1:0] eccentric_anomaly;

	modport source(output valid, eccentric_anomaly, input ready);
	modport sink(input valid, eccentric_anomaly, output ready);
endinterface

// ----- src/kea_cordic_cell.sv -----
// one registered cordic rotation step
module kea_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [kea_pkg::ZW-1:0]   x_in,
	input  logic signed [kea_pkg::ZW-1:0]   y_in,
	input  logic signed [kea_pkg::ZW-1:0]   z_in,
	output logic signed [kea_pkg::ZW-1:0]   x_out,
	output logic signed [kea_pkg::ZW-1:0]   y_out,
	output logic signed [kea_pkg::ZW-1:0]   z_out
);

	localparam logic signed [kea_pkg::ZW-1:0] ATAN = kea_pkg::atan_q30(STEP);

	logic signed [kea_pkg::ZW-1:0] dx;
	logic signed [kea_pkg::ZW-1:0] dy;

	assign dx = y_in >>> STEP;
	assign dy = x_in >>> STEP;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[kea_pkg::ZW-1]) begin
				x_out <= x_in - dx;
				y_out <= y_in + dy;
				z_out <= z_in - ATAN;
			end else begin
				x_out <= x_in + dx;
				y_out <= y_in - dy;
				z_out <= z_in + ATAN;
			end
		end
	end

endmodule

// ----- src/kea_bisect_cell.sv -----
// one bisection step: midpoint, angle reduction, cordic sine, residual sign, bracket update
module kea_bisect_cell #(
	parameter int ANGLE_FRACTION_BITS = 28,
	parameter int AW = 40
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [AW-1:0]          in_lo,
	input  logic signed [AW-1:0]          in_hi,
	input  logic signed [AW-1:0]          in_l,
	input  logic [kea_pkg::E_W-1:0]       in_e,
	output logic                          out_valid,
	output logic signed [AW-1:0]          out_lo,
	output logic signed [AW-1:0]          out_hi,
	output logic signed [AW-1:0]          out_l,
	output logic [kea_pkg::E_W-1:0]       out_e
);

	localparam int F = ANGLE_FRACTION_BITS;
	localparam int ZW = kea_pkg::ZW;
	localparam int NC = kea_pkg::CORDIC_STEPS;
	localparam int QB = (F < 32) ? (34 - F) : 2;
	localparam int NS = QB + 37;
	localparam int PW = 2 * kea_pkg::E_W;
	localparam logic [63:0] PI64 = ((kea_pkg::PI_Q62 >> (61 - F)) + 64'd1) >> 1;
	localparam logic signed [AW-1:0] PI_A = AW'(PI64);
	localparam logic signed [AW-1:0] TWO_PI = PI_A <<< 1;
	localparam logic signed [AW-1:0] HALF_PI = PI_A >>> 1;
	localparam logic signed [AW-1:0] OFFSET = TWO_PI <<< (QB - 1);

	typedef struct packed {
		logic signed [AW-1:0]    lo;
		logic signed [AW-1:0]    hi;
		logic signed [AW-1:0]    l;
		logic signed [AW-1:0]    mid;
		logic [kea_pkg::E_W-1:0] e;
	} carry_t;

	carry_t c_q [0:NS-1];
	logic   v_q [0:NS-1];

	logic signed [AW-1:0] red_q [0:QB];
	logic signed [AW-1:0] fold_q;
	logic signed [AW-1:0] r1;
	logic signed [AW-1:0] r2;
	logic signed [AW-1:0] mag;
	logic signed [ZW-1:0] z0;
	logic signed [ZW-1:0] z0_q;
	logic                 neg_q [0:NC];
	logic signed [ZW-1:0] cx [0:NC];
	logic signed [ZW-1:0] cy [0:NC];
	logic signed [ZW-1:0] cz [0:NC];
	logic signed [ZW-1:0] s;
	logic [kea_pkg::E_W-1:0] smag_q;
	logic                 sneg_q;
	logic [PW-1:0]        prod_q;
	logic                 pneg_q;
	logic signed [AW-1:0] es_mag;
	logic signed [AW-1:0] es;
	logic signed [AW-1:0] res;
	logic                 geq;

	// valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) v_q[i] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
			for (int i = 1; i < NS; i++) v_q[i] <= v_q[i-1];
		end
	end

	// carried bracket and operands
	always_ff @(posedge clk) begin
		if (en) begin
			c_q[0].lo  <= in_lo;
			c_q[0].hi  <= in_hi;
			c_q[0].l   <= in_l;
			c_q[0].e   <= in_e;
			c_q[0].mid <= in_lo + ((in_hi - in_lo) >>> 1);
			for (int i = 1; i < NS - 1; i++) c_q[i] <= c_q[i-1];
			c_q[NS-1].lo  <= geq ? c_q[NS-2].mid : c_q[NS-2].lo;
			c_q[NS-1].hi  <= geq ? c_q[NS-2].hi : c_q[NS-2].mid;
			c_q[NS-1].l   <= c_q[NS-2].l;
			c_q[NS-1].e   <= c_q[NS-2].e;
			c_q[NS-1].mid <= c_q[NS-2].mid;
		end
	end

	// shift the angle positive, then restoring reduction modulo two pi
	always_ff @(posedge clk) begin
		if (en) red_q[0] <= c_q[0].mid + OFFSET;
	end

	for (genvar j = 0; j < QB; j++) begin : g_reduce
		localparam logic signed [AW-1:0] M = TWO_PI <<< (QB - 1 - j);
		always_ff @(posedge clk) begin
			if (en) red_q[j+1] <= (red_q[j] >= M) ? red_q[j] - M : red_q[j];
		end
	end

	// fold into the half circle around zero
	always_comb begin
		r1 = (red_q[QB] > PI_A) ? red_q[QB] - TWO_PI : red_q[QB];
		if (r1 > HALF_PI)
			r2 = PI_A - r1;
		else if (r1 < -HALF_PI)
			r2 = -PI_A - r1;
		else
			r2 = r1;
	end

	always_ff @(posedge clk) begin
		if (en) fold_q <= r2;
	end

	assign mag = fold_q[AW-1] ? -fold_q : fold_q;

	if (F >= 30) begin : g_to_q30_down
		assign z0 = ZW'(mag >>> (F - 30));
	end else begin : g_to_q30_up
		assign z0 = ZW'(mag <<< (30 - F));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z0_q     <= z0;
			neg_q[0] <= fold_q[AW-1];
			for (int i = 1; i <= NC; i++) neg_q[i] <= neg_q[i-1];
		end
	end

	assign cx[0] = kea_pkg::CORDIC_GAIN_Q30;
	assign cy[0] = '0;
	assign cz[0] = z0_q;

	for (genvar i = 0; i < NC; i++) begin : g_cordic
		kea_cordic_cell #(.STEP(i)) u_cell (
			.clk   (clk),
			.en    (en),
			.x_in  (cx[i]),
			.y_in  (cy[i]),
			.z_in  (cz[i]),
			.x_out (cx[i+1]),
			.y_out (cy[i+1]),
			.z_out (cz[i+1])
		);
	end

	assign s = neg_q[NC] ? -cy[NC] : cy[NC];

	always_ff @(posedge clk) begin
		if (en) begin
			sneg_q <= s[ZW-1];
			smag_q <= kea_pkg::E_W'(s[ZW-1] ? -s : s);
			prod_q <= PW'(c_q[QB+34].e) * PW'(smag_q);
			pneg_q <= sneg_q;
		end
	end

	// residual l - u + e sin u and bracket decision
	always_comb begin
		es_mag = AW'(prod_q >> (61 - F));
		es     = pneg_q ? -es_mag : es_mag;
		res    = c_q[NS-2].l - c_q[NS-2].mid + es;
		geq    = !res[AW-1];
	end

	assign out_valid = v_q[NS-1];
	assign out_lo    = c_q[NS-1].lo;
	assign out_hi    = c_q[NS-1].hi;
	assign out_l     = c_q[NS-1].l;
	assign out_e     = c_q[NS-1].e;

endmodule

// ----- src/kepler_eccentric_anomaly_core.sv -----
// kepler equation solver: chain of bisection cells with an output buffer
//
//  channel   dir  payload
//  operand   in   eccentricity (31b unsigned Q31), mean_anomaly (32b signed)
//  result    out  eccentric_anomaly (32b signed, same scale as mean_anomaly)
//
// one transfer per cycle while the buffer is not full; each operand passes an input register,
// the chain of bisection cells, each with its angle reduction and 30-step cordic pipeline,
// and an output register in front of the buffer
// reset clears valid bits, the buffer count and the buffer pointers only
// a two-entry output buffer keeps taking transfers while one result waits;
// the whole pipeline holds when the buffer is full
module kepler_eccentric_anomaly_core #(
	parameter int BISECTION_STEPS = 30,
	parameter int ANGLE_FRACTION_BITS = 28
) (
	input  logic       clk,
	input  logic       arst_n,
	kea_in_if.sink     operand,
	kea_out_if.source  result
);

	localparam int F = ANGLE_FRACTION_BITS;
	localparam int AW = ((F > 32) ? F : 32) + 8;
	localparam int DW = kea_pkg::DATA_W;
	localparam logic signed [AW-1:0] ONE = AW'(1) <<< F;
	localparam logic signed [AW-1:0] SAT_MAX = AW'(33'sh0_7FFFFFFF);
	localparam logic signed [AW-1:0] SAT_MIN = AW'(33'sh1_80000000);

	logic                          en;
	logic                          v_s1;
	logic signed [AW-1:0]          l_s1;
	logic signed [AW-1:0]          lo_s1;
	logic signed [AW-1:0]          hi_s1;
	logic [kea_pkg::E_W-1:0]       e_s1;
	logic signed [AW-1:0]          l_ext;

	logic                          v_c  [0:BISECTION_STEPS];
	logic signed [AW-1:0]          lo_c [0:BISECTION_STEPS];
	logic signed [AW-1:0]          hi_c [0:BISECTION_STEPS];
	logic signed [AW-1:0]          l_c  [0:BISECTION_STEPS];
	logic [kea_pkg::E_W-1:0]       e_c  [0:BISECTION_STEPS];

	logic                          v_s2;
	logic signed [DW-1:0]          sat_s2;
	logic signed [DW-1:0]          sat;

	logic signed [DW-1:0]          buf_q [0:1];
	logic [1:0]                    count_q;
	logic                          wr_q;
	logic                          rd_q;
	logic                          push;
	logic                          pop;

	assign en = (count_q != 2'd2);
	assign operand.ready = en;
	assign l_ext = AW'(operand.mean_anomaly);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= operand.valid;
			v_s2 <= v_c[BISECTION_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s1   <= l_ext;
			lo_s1  <= l_ext - ONE;
			hi_s1  <= l_ext + ONE;
			e_s1   <= operand.eccentricity;
			sat_s2 <= sat;
		end
	end

	assign v_c[0]  = v_s1;
	assign lo_c[0] = lo_s1;
	assign hi_c[0] = hi_s1;
	assign l_c[0]  = l_s1;
	assign e_c[0]  = e_s1;

	for (genvar k = 0; k < BISECTION_STEPS; k++) begin : g_step
		kea_bisect_cell #(
			.ANGLE_FRACTION_BITS (F),
			.AW                  (AW)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v_c[k]),
			.in_lo     (lo_c[k]),
			.in_hi     (hi_c[k]),
			.in_l      (l_c[k]),
			.in_e      (e_c[k]),
			.out_valid (v_c[k+1]),
			.out_lo    (lo_c[k+1]),
			.out_hi    (hi_c[k+1]),
			.out_l     (l_c[k+1]),
			.out_e     (e_c[k+1])
		);
	end

	// saturate to the output range
	always_comb begin
		if (lo_c[BISECTION_STEPS] > SAT_MAX)
			sat = DW'(SAT_MAX);
		else if (lo_c[BISECTION_STEPS] < SAT_MIN)
			sat = DW'(SAT_MIN);
		else
			sat = DW'(lo_c[BISECTION_STEPS]);
	end

	assign push = en && v_s2;
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= sat_s2;
	end

	assign result.valid = (count_q != 2'd0);
	assign result.eccentric_anomaly = buf_q[rd_q];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("output buffer count out of range");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push && count_q == 2'd1) |=> !result.valid)
		else $error("result still valid after last entry drained");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && v_s2) |=> (v_s2 && $stable(sat_s2)))
		else $error("last stage lost its item during a stall");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2 && !pop) |=> (count_q == 2'd2))
		else $error("full buffer changed without a transfer out");

endmodule

// ----- tb/kepler_eccentric_anomaly_core_test.sv -----
// testbench for kepler_eccentric_anomaly_core: bit-exact bisection/cordic predictor with scoreboard
`timescale 1ns / 1ps

module kepler_eccentric_anomaly_core_test;

	localparam int STEPS = 30;
	localparam int FRAC = 28;
	localparam int LATENCY = 2 + STEPS * ((34 - FRAC) + 37);
	localparam int CYCLE_LIMIT = 600000;
	localparam longint SINE_GAIN = 64'h26DD3B6A;
	localparam longint ARCTAN [30] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
		64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
	};

	logic clk;
	logic arst_n;
	kea_in_if operand ();
	kea_out_if result ();

	logic signed [kea_pkg::DATA_W-1:0] anomaly_queue [$];
	int mismatches = 0;
	int burst_left = 0;
	int stall_left = 0;
	longint cycles = 0;

	kepler_eccentric_anomaly_core #(
		.BISECTION_STEPS(STEPS),
		.ANGLE_FRACTION_BITS(FRAC)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.operand(operand),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint sine_q30(input longint a);
		logic [63:0] pw;
		longint pi_f, two_pi, half_pi, r, x, y, z, dx, dy;
		bit neg;
		pw = ((64'hC90FDAA22168C235 >> (61 - FRAC)) + 64'd1) >> 1;
		pi_f = longint'(pw);
		two_pi = 2 * pi_f;
		half_pi = pi_f >>> 1;
		r = a % two_pi;
		if (r < 0) r += two_pi;
		if (r > pi_f) r -= two_pi;
		if (r > half_pi) r = pi_f - r;
		else if (r < -half_pi) r = -pi_f - r;
		neg = r < 0;
		z = neg ? -r : r;
		z = z << (30 - FRAC);
		x = SINE_GAIN;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ARCTAN[i];
			end else begin
				x += dx;
				y -= dy;
				z += ARCTAN[i];
			end
		end
		return neg ? -y : y;
	endfunction

	function automatic longint kepler_residual(input longint e, input longint l, input longint u);
		longint s, smag, prod;
		s = sine_q30(u);
		smag = (s < 0) ? -s : s;
		prod = (e * smag) >>> (61 - FRAC);
		return l - u + ((s < 0) ? -prod : prod);
	endfunction

	function automatic logic signed [kea_pkg::DATA_W-1:0] kepler_root(
			input logic [kea_pkg::E_W-1:0] ecc,
			input logic signed [kea_pkg::DATA_W-1:0] mean);
		longint e, l, lo, hi, mid;
		e = longint'({33'b0, ecc});
		l = longint'(mean);
		lo = l - (longint'(1) << FRAC);
		hi = l + (longint'(1) << FRAC);
		for (int k = 0; k < STEPS; k++) begin
			mid = lo + ((hi - lo) >>> 1);
			if (kepler_residual(e, l, mid) >= 0) lo = mid;
			else hi = mid;
		end
		if (lo > longint'(32'sh7FFFFFFF)) lo = longint'(32'sh7FFFFFFF);
		if (lo < -longint'(64'h80000000)) lo = -longint'(64'h80000000);
		return lo[kea_pkg::DATA_W-1:0];
	endfunction

	task automatic send_item(input logic [kea_pkg::E_W-1:0] ecc,
			input logic signed [kea_pkg::DATA_W-1:0] mean);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				operand.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		operand.valid <= 1'b1;
		operand.eccentricity <= ecc;
		operand.mean_anomaly <= mean;
		do @(posedge clk); while (!operand.ready);
		anomaly_queue.push_back(kepler_root(ecc, mean));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		operand.valid <= 1'b0;
		burst_left = 0;
		while (anomaly_queue.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_directed();
		logic [kea_pkg::E_W-1:0] ecc_set [4];
		logic signed [kea_pkg::DATA_W-1:0] mean_set [6];
		ecc_set = '{31'd0, 31'h7FFFFFFF, 31'h40000000, 31'h55555555};
		mean_set = '{32'sh80000000, 32'sh7FFFFFFF, 32'sd0, 32'sh3243F6A9, -32'sh3243F6A9,
			32'sh7FF00000};
		foreach (ecc_set[i])
			foreach (mean_set[j])
				send_item(ecc_set[i], mean_set[j]);
		send_item(31'h7FFFFFFF, 32'sh10000000);
	endtask

	task automatic test_random(input int count);
		logic signed [kea_pkg::DATA_W-1:0] mean;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 3))
				0: mean = $urandom;
				1: mean = $signed($urandom_range(0, 32'h7FFFFFF)) - 32'sh4000000;
				2: mean = $urandom_range(0, 1) ? 32'sh7FFFFFFF - $urandom_range(0, 32'h3FFFFFF)
					: 32'sh80000000 + $urandom_range(0, 32'h3FFFFFF);
				default: mean = $signed($urandom_range(0, 32'h7FFFFF)) - 32'sh400000;
			endcase
			send_item($urandom_range(0, 1) ? 31'($urandom)
				: 31'(31'h7FFFFFFF - $urandom_range(0, 255)), mean);
		end
	endtask

	task automatic test_drain_pause();
		test_random(40);
		wait_drained();
		test_random(40);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
			if (((cycles / 3000) % 3) != 0 && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 12);
		end
	end

	always @(posedge clk) begin
		logic signed [kea_pkg::DATA_W-1:0] want;
		cycles++;
		if (arst_n && result.valid && result.ready) begin
			if (anomaly_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: eccentric_anomaly=%h", result.eccentric_anomaly);
			end else begin
				want = anomaly_queue.pop_front();
				if (result.eccentric_anomaly !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: eccentric_anomaly expected %h actual %h",
							want, result.eccentric_anomaly);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("kepler_eccentric_anomaly_core regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		operand.valid = 1'b0;
		operand.eccentricity = '0;
		operand.mean_anomaly = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_drain_pause();
		test_random(830);
		wait_drained();
		repeat (LATENCY + 100) @(posedge clk);
		if (mismatches == 0 && anomaly_queue.size() == 0)
			$display("kepler_eccentric_anomaly_core regression: pass");
		else
			$display("kepler_eccentric_anomaly_core regression: fail");
		$finish;
	end

endmodule

// ----- files.f -----
src/kea_pkg.sv
src/kea_in_if.sv
src/kea_out_if.sv
src/kea_cordic_cell.sv
src/kea_bisect_cell.sv
src/kepler_eccentric_anomaly_core.sv
tb/kepler_eccentric_anomaly_core_test.sv
